/* src/wildcard_glob_matcher_top_macros.svh */
// Assertion macros of the wildcard glob matcher RTL.
// Included by wildcard_glob_matcher_top, which checks its own logic; needs no package.
`ifndef WILDCARD_GLOB_MATCHER_TOP_MACROS_SVH
`define WILDCARD_GLOB_MATCHER_TOP_MACROS_SVH

// Implication in the same cycle, checked outside reset.
`define WGM_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wildcard glob matcher check failed");

// Implication in the next cycle, checked outside reset.
`define WGM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wildcard glob matcher check failed");

`endif

/* src/wgm_pkg.sv */
// Types and constants of the wildcard glob matcher.
// Used by wgm_cell and wildcard_glob_matcher_top; depends on nothing else.
package wgm_pkg;

   // Number of token cells in the chain.
   localparam int MaxTokens = 32;

   // Special pattern bytes.
   localparam logic [7:0] CH_ESCAPE = 8'h5C;
   localparam logic [7:0] CH_RUN    = 8'h2A;
   localparam logic [7:0] CH_ONE    = 8'h3F;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_TEXT   = 2'd2,
      OP_REPORT = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      KIND_LIT = 2'd0,
      KIND_ONE = 2'd1,
      KIND_RUN = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      FAULT_OK       = 2'd0,
      FAULT_ESCAPE   = 2'd1,
      FAULT_OVERFLOW = 2'd2
   } fault_type;

   // Commands broadcast from the top level to every cell.
   typedef struct packed {
      logic       clear;      // drop all tokens
      logic       add;        // append one token at the tail
      kind_type   kind;       // kind of the appended token
      logic [7:0] tok_char;   // byte of an appended literal
      logic       rearm;      // restart the position set at position zero
      logic       text;       // advance the position set by one text byte
      logic [7:0] text_byte;
   } ctrl_type;

   // Data handed from one cell to its right neighbor.
   typedef struct packed {
      logic head;      // set only at the chain input: position zero lives here
      logic valid;     // the left cell holds a token
      logic run_gate;  // the left position is active and its token is a run
      logic adv;       // the left token consumed the text byte
   } link_type;

   // Per-cell status seen by the top level.
   typedef struct packed {
      logic valid;
      logic pos;
      logic run;
      logic hit;       // this position is the pattern end and is active
   } cell_stat_type;

endpackage

/* src/wgm_cell.sv */
// One token cell of the wildcard glob matcher chain.
// Holds one token and one position bit; depends on wgm_pkg.
module wgm_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  wgm_pkg::ctrl_type     ctrl,
   input  wgm_pkg::link_type     link_in,
   output wgm_pkg::link_type     link_out,
   output wgm_pkg::cell_stat_type stat
);
   import wgm_pkg::*;

   logic       valid_ff, valid_in;
   logic       pos_ff, pos_in;
   kind_type   kind_ff;
   logic [7:0] char_ff;
   logic       is_run;
   logic       closed;
   logic       target;
   logic       step;

   // Closure over a run token on the left: stars never follow each other,
   // so one neighbor step is the whole closure.
   assign is_run = valid_ff & (kind_ff == KIND_RUN);
   assign closed = pos_ff | link_in.run_gate;
   assign target = link_in.valid & ~valid_ff;
   assign step   = closed & valid_ff &
                   ((kind_ff == KIND_ONE) ||
                    ((kind_ff == KIND_LIT) && (char_ff == ctrl.text_byte)));

   // Hand the neighbor what it needs.
   assign link_out.head     = 1'b0;
   assign link_out.valid    = valid_ff;
   assign link_out.run_gate = pos_ff & is_run;
   assign link_out.adv      = step;

   assign stat.valid = valid_ff;
   assign stat.pos   = pos_ff;
   assign stat.run   = is_run;
   assign stat.hit   = closed & target;

   // Next token occupancy and position bit.
   always_comb begin
      valid_in = valid_ff;
      if (ctrl.clear) begin
         valid_in = 1'b0;
      end else if (ctrl.add && target) begin
         valid_in = 1'b1;
      end

      pos_in = pos_ff;
      if (ctrl.rearm) begin
         pos_in = link_in.head;
      end else if (ctrl.text) begin
         pos_in = (closed & is_run) | link_in.adv;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pos_ff   <= link_in.head;
      end else begin
         valid_ff <= valid_in;
         pos_ff   <= pos_in;
      end
   end

   // Token payload, written once when this cell becomes the tail.
   always_ff @(posedge clock) begin
      if (ctrl.add && target) begin
         kind_ff <= ctrl.kind;
         char_ff <= ctrl.tok_char;
      end
   end

endmodule

/* src/wildcard_glob_matcher_top.sv */
// Top level of the wildcard glob matcher: pattern parser, token cell chain
// and result register. Depends on wgm_pkg, wgm_cell and the assertion macros.
//
// Load a pattern with a clear transfer and then one append transfer per
// pattern byte ('*' any run, '?' any one byte, backslash escapes the next
// byte); stream text bytes; a report transfer returns one result with the
// match flag and a fault code, and rearms the matcher for the next text.
// Each token cell updates its position bit from its left neighbor in the
// same cycle, so the block accepts one item per clock, and a report result
// appears on the result channel the cycle after its transfer. The input
// stalls only while a result is held and the result channel is not ready.
// The chain holds 32 tokens; longer patterns report an overflow fault.
`include "wildcard_glob_matcher_top_macros.svh"

module wildcard_glob_matcher_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic [1:0]  req_tuser,   // [1:0] op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // [0] matched, [2:1] fault, [7:3] zero
);
   import wgm_pkg::*;

   ctrl_type      ctrl;
   link_type      links [0:MaxTokens];
   cell_stat_type stats [0:MaxTokens-1];

   logic [MaxTokens-1:0] valid_vec;
   logic [MaxTokens-1:0] run_vec;
   logic [MaxTokens-1:0] hit_vec;
   logic [MaxTokens:0]   pos_vec;

   logic      escape_ff, escape_in;
   logic      overflow_ff, overflow_in;
   logic      pos_last_ff, pos_last_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      matched_ff, matched_in;
   fault_type fault_ff, fault_in;

   logic      accept;
   op_type    op;
   logic      append;
   logic      token_ok;
   logic      tail_run;
   logic      full;
   logic      hit_last;
   logic      hit;

   // Input transfer and command decode.
   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign accept     = req_tvalid & req_tready;
   assign op         = op_type'(req_tuser);
   assign append     = accept & (op == OP_APPEND);

   assign tail_run = |(run_vec & ~(valid_vec >> 1));
   assign full     = valid_vec[MaxTokens-1];

   // Pattern parser: decide which token, if any, an append byte yields.
   always_comb begin
      ctrl.clear     = accept & (op == OP_CLEAR);
      ctrl.rearm     = accept & (op != OP_TEXT);
      ctrl.text      = accept & (op == OP_TEXT);
      ctrl.text_byte = req_tdata;
      ctrl.tok_char  = req_tdata;
      ctrl.kind      = KIND_LIT;
      token_ok       = 1'b1;
      escape_in      = escape_ff;
      if (escape_ff) begin
         escape_in = 1'b0;
      end else if (req_tdata == CH_ESCAPE) begin
         escape_in = 1'b1;
         token_ok  = 1'b0;
      end else if (req_tdata == CH_RUN) begin
         ctrl.kind     = KIND_RUN;
         ctrl.tok_char = 8'h00;
         token_ok      = ~tail_run;
      end else if (req_tdata == CH_ONE) begin
         ctrl.kind     = KIND_ONE;
         ctrl.tok_char = 8'h00;
      end
      if (!append) begin
         escape_in = escape_ff;
      end
      if (ctrl.clear) begin
         escape_in = 1'b0;
      end
      ctrl.add    = append & token_ok & ~full;
      overflow_in = ctrl.clear ? 1'b0 : (overflow_ff | (append & token_ok & full));
   end

   // Chain of token cells; position zero enters at the head link.
   assign links[0] = '{head: 1'b1, valid: 1'b1, run_gate: 1'b0, adv: 1'b0};

   for (genvar i = 0; i < MaxTokens; i++) begin : g_cell
      wgm_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .link_in  (links[i]),
         .link_out (links[i+1]),
         .stat     (stats[i])
      );
      assign valid_vec[i] = stats[i].valid;
      assign run_vec[i]   = stats[i].run;
      assign hit_vec[i]   = stats[i].hit;
      assign pos_vec[i]   = stats[i].pos;
   end
   assign pos_vec[MaxTokens] = pos_last_ff;

   // Position after the last cell: every token of a full store matched.
   assign hit_last = (pos_last_ff | links[MaxTokens].run_gate) & links[MaxTokens].valid;
   assign hit      = (|hit_vec) | hit_last;

   always_comb begin
      pos_last_in = pos_last_ff;
      if (ctrl.rearm) begin
         pos_last_in = 1'b0;
      end else if (ctrl.text) begin
         pos_last_in = links[MaxTokens].adv;
      end
   end

   // Result register; a report transfer loads it, the result transfer frees it.
   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      matched_in   = matched_ff;
      fault_in     = fault_ff;
      if (accept && (op == OP_REPORT)) begin
         rsp_valid_in = 1'b1;
         if (overflow_ff) begin
            fault_in = FAULT_OVERFLOW;
         end else if (escape_ff) begin
            fault_in = FAULT_ESCAPE;
         end else begin
            fault_in = FAULT_OK;
         end
         matched_in = hit & ~overflow_ff & ~escape_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         escape_ff    <= 1'b0;
         overflow_ff  <= 1'b0;
         pos_last_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         escape_ff    <= escape_in;
         overflow_ff  <= overflow_in;
         pos_last_ff  <= pos_last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      matched_ff <= matched_in;
      fault_ff   <= fault_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b00000, fault_ff, matched_ff};

   // Tokens fill the chain from the head without gaps.
   `WGM_ASSERT_SAME(a_valid_packed, clock, reset, 1'b1,
      ((valid_vec >> 1) & ~valid_vec) == '0)
   // No position beyond the pattern end is ever active.
   `WGM_ASSERT_SAME(a_pos_in_range, clock, reset, 1'b1,
      (pos_vec & ~{valid_vec, 1'b1}) == '0)
   // Merged stars: two run tokens never sit side by side.
   `WGM_ASSERT_SAME(a_no_double_run, clock, reset, 1'b1,
      (run_vec & (run_vec >> 1)) == '0)
   // A clear leaves an empty store with only position zero active.
   `WGM_ASSERT_NEXT(a_clear_empties, clock, reset, accept && (op == OP_CLEAR),
      (valid_vec == '0) && (pos_vec == {{MaxTokens{1'b0}}, 1'b1}) && !overflow_ff)
   // A fault never comes with a match.
   `WGM_ASSERT_SAME(a_fault_no_match, clock, reset, rsp_valid_ff && matched_ff,
      fault_ff == FAULT_OK)

endmodule
